/* hw/rtl/lpd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants for the length-prefixed record deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned PHASE_W       = 2;
  localparam int unsigned PLEN_W        = 64;
  localparam int unsigned NLEN_W        = 32;
  localparam int unsigned LEN_HDR_BYTES  = 8;
  localparam int unsigned NAME_HDR_BYTES = 4;
  localparam int unsigned HDR_CNT_W     = 3;
  localparam logic [BYTE_W-1:0] MAX_NAME_RESET = 8'hFF;

  // phase codes as seen on the output
  localparam logic [PHASE_W-1:0] PH_LEN     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_NAMELEN = 2'd1;
  localparam logic [PHASE_W-1:0] PH_NAME    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_PAYLOAD = 2'd3;

  typedef enum logic [3:0] {
    S_LEN     = 4'b0001,
    S_NAMELEN = 4'b0010,
    S_NAME    = 4'b0100,
    S_PAYLOAD = 4'b1000
  } lpd_state_t;

  // one classified byte, front to back
  typedef struct packed {
    logic [BYTE_W-1:0]  byte_value;
    logic [PHASE_W-1:0] phase;
    logic               lengths_valid;
    logic               name_last;
    logic               record_last;
    logic [PLEN_W-1:0]  payload_length;
    logic [NLEN_W-1:0]  name_length;
  } lpd_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } lpd_q_stat_t;

  function automatic logic [PHASE_W-1:0] phase_code(input lpd_state_t s);
    logic [PHASE_W-1:0] p;
    case (s)
      S_LEN:     p = PH_LEN;
      S_NAMELEN: p = PH_NAMELEN;
      S_NAME:    p = PH_NAME;
      S_PAYLOAD: p = PH_PAYLOAD;
      default:   p = PH_LEN;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/lpd_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd channel interfaces
// Valid/ready channels for input bytes, parsed results and configuration.
// ----------------------------------------------------------------------------
interface lpd_in_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface lpd_out_if;
  import lpd_pkg::*;
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  byte_value;
  logic [PHASE_W-1:0] phase;
  logic [PLEN_W-1:0]  payload_length;
  logic [NLEN_W-1:0]  name_length;
  logic               name_too_long;
  logic               name_last;
  logic               record_last;
  modport source (output valid, output byte_value, output phase, output payload_length,
                  output name_length, output name_too_long, output name_last,
                  output record_last, input ready);
  modport sink   (input valid, input byte_value, input phase, input payload_length,
                  input name_length, input name_too_long, input name_last,
                  input record_last, output ready);
endinterface

interface lpd_cfg_if;
  import lpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/lpd_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_front
// Header/name/payload parser: takes one byte per transfer and classifies it.
// ----------------------------------------------------------------------------
module lpd_front (
  input  wire logic                clk,
  input  wire logic                rst,
  lpd_in_if.sink                   rx,
  input  wire lpd_pkg::lpd_q_stat_t q_stat,
  output logic                     push,
  output lpd_pkg::lpd_item_t       item
);
  import lpd_pkg::*;

  lpd_state_t           state, state_next;
  logic [HDR_CNT_W-1:0] hdr_cnt, hdr_cnt_next;
  logic [PLEN_W-1:0]    plen, plen_next;
  logic [NLEN_W-1:0]    nlen, nlen_next;
  logic [PLEN_W-1:0]    pos, pos_next;
  logic [PLEN_W-1:0]    pos_inc;
  logic                 lengths_valid, name_last, record_last;

  assign rx.ready = !q_stat.full;
  assign push     = rx.valid && rx.ready;
  assign pos_inc  = pos + PLEN_W'(1);

  always_comb begin
    state_next    = state;
    hdr_cnt_next  = hdr_cnt;
    plen_next     = plen;
    nlen_next     = nlen;
    pos_next      = pos;
    lengths_valid = 1'b0;
    name_last     = 1'b0;
    record_last   = 1'b0;
    case (state)
      S_LEN: begin
        plen_next = {plen[PLEN_W-BYTE_W-1:0], rx.data_byte};
        if (hdr_cnt == HDR_CNT_W'(LEN_HDR_BYTES - 1)) begin
          hdr_cnt_next = '0;
          state_next   = S_NAMELEN;
        end else begin
          hdr_cnt_next = hdr_cnt + HDR_CNT_W'(1);
        end
      end
      S_NAMELEN: begin
        nlen_next = {nlen[NLEN_W-BYTE_W-1:0], rx.data_byte};
        if (hdr_cnt == HDR_CNT_W'(NAME_HDR_BYTES - 1)) begin
          hdr_cnt_next  = '0;
          pos_next      = '0;
          lengths_valid = 1'b1;
          if (nlen_next == '0) begin
            name_last = 1'b1;
            if (plen == '0) record_last = 1'b1;
            else            state_next  = S_PAYLOAD;
          end else begin
            state_next = S_NAME;
          end
        end else begin
          hdr_cnt_next = hdr_cnt + HDR_CNT_W'(1);
        end
      end
      S_NAME: begin
        lengths_valid = 1'b1;
        pos_next      = pos_inc;
        if (pos_inc >= {{(PLEN_W-NLEN_W){1'b0}}, nlen}) begin
          name_last = 1'b1;
          pos_next  = '0;
          if (plen == '0) record_last = 1'b1;
          else            state_next  = S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        lengths_valid = 1'b1;
        pos_next      = pos_inc;
        if (pos_inc >= plen) record_last = 1'b1;
      end
      default: state_next = S_LEN;
    endcase
  end

  always_comb begin
    item.byte_value     = rx.data_byte;
    item.phase          = phase_code(state);
    item.lengths_valid  = lengths_valid;
    item.name_last      = name_last;
    item.record_last    = record_last;
    item.payload_length = plen_next;
    item.name_length    = nlen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LEN;
      hdr_cnt <= '0;
      plen    <= '0;
      nlen    <= '0;
      pos     <= '0;
    end else if (push) begin
      if (record_last) begin
        state   <= S_LEN;
        hdr_cnt <= '0;
        plen    <= '0;
        nlen    <= '0;
        pos     <= '0;
      end else begin
        state   <= state_next;
        hdr_cnt <= hdr_cnt_next;
        plen    <= plen_next;
        nlen    <= nlen_next;
        pos     <= pos_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lpd_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_queue
// Two-entry queue between parser and output stage.
// ----------------------------------------------------------------------------
module lpd_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire lpd_pkg::lpd_item_t  wr_item,
  input  wire logic                pop,
  output lpd_pkg::lpd_item_t       rd_item,
  output lpd_pkg::lpd_q_stat_t     q_stat
);
  import lpd_pkg::*;

  lpd_item_t  entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign rd_item      = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lpd_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_back
// Output stage: holds max_name_bytes, flags overlong names, registers results.
// ----------------------------------------------------------------------------
module lpd_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  lpd_cfg_if.sink                   cfg,
  input  wire lpd_pkg::lpd_q_stat_t q_stat,
  input  wire lpd_pkg::lpd_item_t   rd_item,
  output logic                      pop,
  lpd_out_if.source                 tx
);
  import lpd_pkg::*;

  logic [BYTE_W-1:0] max_name_bytes;
  logic              out_valid;

  assign cfg.ready = 1'b1;
  assign tx.valid  = out_valid;
  assign pop       = !q_stat.empty && (!out_valid || tx.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_name_bytes <= MAX_NAME_RESET;
    end else if (cfg.valid && cfg.ready) begin
      max_name_bytes <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  // lengths read as zero until both headers are complete
  always_ff @(posedge clk) begin
    if (pop) begin
      tx.byte_value     <= rd_item.byte_value;
      tx.phase          <= rd_item.phase;
      tx.name_last      <= rd_item.name_last;
      tx.record_last    <= rd_item.record_last;
      tx.payload_length <= rd_item.lengths_valid ? rd_item.payload_length : '0;
      tx.name_length    <= rd_item.lengths_valid ? rd_item.name_length : '0;
      tx.name_too_long  <= rd_item.lengths_valid &&
                           (rd_item.name_length > {{(NLEN_W-BYTE_W){1'b0}}, max_name_bytes});
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/length_prefixed_record_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_record_deframer
// Parses a byte stream of length-prefixed records and tags each byte.
// ----------------------------------------------------------------------------
// Takes one byte per cycle while the queue is not full and delivers one result
// per byte, in order. A record is an 8-byte big-endian payload length, a 4-byte
// big-endian name length, the name bytes and the payload bytes. Each result
// carries the byte, its phase, the decoded lengths (zero until both headers are
// in), an overlong-name flag against max_name_bytes, and name/record end marks.
// Empty names and empty payloads end right after the preceding field. Results
// pass through a two-entry queue and an output register, which let rx keep
// flowing while a result waits on tx; throughput is one byte per cycle while tx
// accepts, set by the combinational parser update (64-bit position increment
// and compare). The cfg channel is always ready; write it only while idle.
// ----------------------------------------------------------------------------
module length_prefixed_record_deframer (
  input  wire logic clk,
  input  wire logic rst,
  lpd_in_if.sink    rx,
  lpd_out_if.source tx,
  lpd_cfg_if.sink   cfg
);
  import lpd_pkg::*;

  lpd_item_t   wr_item, rd_item;
  lpd_q_stat_t q_stat;
  logic        push, pop;

  lpd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_stat (q_stat),
    .push   (push),
    .item   (wr_item)
  );

  lpd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (wr_item),
    .pop     (pop),
    .rd_item (rd_item),
    .q_stat  (q_stat)
  );

  lpd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_stat  (q_stat),
    .rd_item (rd_item),
    .pop     (pop),
    .tx      (tx)
  );

endmodule
`default_nettype wire

/* hw/rtl/lpd_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lpd_checker
// Port-level checks on the deframer output, bound to the top level.
// ----------------------------------------------------------------------------
module lpd_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         tx_valid,
  input wire logic [lpd_pkg::PHASE_W-1:0]  tx_phase,
  input wire logic [lpd_pkg::PLEN_W-1:0]   tx_payload_length,
  input wire logic [lpd_pkg::NLEN_W-1:0]   tx_name_length,
  input wire logic                         tx_name_too_long,
  input wire logic                         tx_name_last,
  input wire logic                         tx_record_last
);
  import lpd_pkg::*;

  a_reset_idle: assert property (@(posedge clk) rst |=> !tx_valid)
    else $error("tx valid after reset");

  a_len_phase_clean: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_phase == PH_LEN) |->
      (tx_payload_length == '0 && tx_name_length == '0 && !tx_name_too_long &&
       !tx_name_last && !tx_record_last))
    else $error("length header byte carries lengths or end marks");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_phase == PH_PAYLOAD) |-> tx_payload_length != '0)
    else $error("payload byte with zero payload length");

  a_too_long_nonzero: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_name_too_long) |-> tx_name_length != '0)
    else $error("overlong flag with empty name");

  a_name_last_phase: assert property (@(posedge clk) disable iff (rst)
    (tx_valid && tx_phase == PH_NAMELEN && tx_name_last) |-> tx_name_length == '0)
    else $error("name end on header with nonzero name length");

endmodule

bind length_prefixed_record_deframer lpd_checker u_lpd_checker (
  .clk               (clk),
  .rst               (rst),
  .tx_valid          (tx.valid),
  .tx_phase          (tx.phase),
  .tx_payload_length (tx.payload_length),
  .tx_name_length    (tx.name_length),
  .tx_name_too_long  (tx.name_too_long),
  .tx_name_last      (tx.name_last),
  .tx_record_last    (tx.record_last)
);
`default_nettype wire
